@@ rtl/core/cnmr_pkg.sv @@
// shared constants, codes and types for the cone nearest-match remove unit
// used by the distance unit and the top level; no dependencies
`default_nettype none

package cnmr_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int SLOT_W      = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	localparam int PT_W   = 16;
	localparam int ANG_W  = 12;
	localparam int R2_W   = 24;
	localparam int TP_W   = 12;
	localparam int SQ_W   = 2 * ANG_W;
	localparam int D2_W   = SQ_W + 1;
	localparam int WORD_W = PT_W + 2 * ANG_W;
	localparam int OSLOT_W = 6;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PT_MIN  = 2'd0,
		CFG_RADIUS2 = 2'd1,
		CFG_TWO_PI  = 2'd2
	} cfg_idx_t;

	// one table entry
	typedef struct packed {
		logic [PT_W-1:0]         pt;
		logic signed [ANG_W-1:0] eta;
		logic signed [ANG_W-1:0] phi;
	} ent_t;

	// control that travels with one candidate down the distance pipe
	typedef struct packed {
		logic              vld;
		logic              ok;
		logic [SLOT_W-1:0] slot;
	} cand_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/cnmr_ram.sv @@
// generic single write port ram with one registered read port
// standalone, no package dependency
`default_nettype none

module cnmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/core/cnmr_dist.sv @@
// squared delta-r unit: three stage pipe, one candidate per cycle
// depends on cnmr_pkg for widths and the candidate structs
`default_nettype none

module cnmr_dist
	import cnmr_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cand_ctl_t               cand_s1,
	input  wire ent_t                    ent_s1,
	input  wire logic signed [ANG_W-1:0] q_eta,
	input  wire logic signed [ANG_W-1:0] q_phi,
	input  wire logic [PT_W-1:0]         pt_min,
	input  wire logic [TP_W-1:0]         two_pi,
	input  wire logic [R2_W-1:0]         radius2,
	output      cand_ctl_t               res_s4,
	output      ent_t                    res_ent_s4,
	output      logic [D2_W-1:0]         res_d2_s4,
	output      logic                    res_hit_s4,
	output      logic                    busy
);

	// stage a: differences, abs, phi wrap
	logic signed [ANG_W:0] de_diff, dp_diff, dp_abs_s, wrap, dp_sel;
	logic [ANG_W-1:0]      de_mag, dp_mag;

	always_comb begin
		de_diff  = {q_eta[ANG_W-1], q_eta} - {ent_s1.eta[ANG_W-1], ent_s1.eta};
		dp_diff  = {q_phi[ANG_W-1], q_phi} - {ent_s1.phi[ANG_W-1], ent_s1.phi};
		dp_abs_s = dp_diff[ANG_W] ? -dp_diff : dp_diff;
		wrap     = $signed({1'b0, two_pi}) - dp_abs_s;
		dp_sel   = (dp_abs_s > wrap) ? wrap : dp_abs_s;
		de_mag   = de_diff[ANG_W] ? ANG_W'(-de_diff) : de_diff[ANG_W-1:0];
		dp_mag   = dp_sel[ANG_W] ? ANG_W'(-dp_sel) : dp_sel[ANG_W-1:0];
	end

	cand_ctl_t        ctl_s2, ctl_s3;
	ent_t             ent_s2, ent_s3;
	logic [ANG_W-1:0] de_s2, dp_s2;
	logic [SQ_W-1:0]  sqe_s3, sqp_s3;
	logic [D2_W-1:0]  sum;

	// candidate control down the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			res_s4 <= '0;
		end else begin
			ctl_s2.vld  <= cand_s1.vld;
			ctl_s2.ok   <= cand_s1.ok && (ent_s1.pt >= pt_min);
			ctl_s2.slot <= cand_s1.slot;
			ctl_s3      <= ctl_s2;
			res_s4      <= ctl_s3;
		end
	end

	assign sum = {1'b0, sqe_s3} + {1'b0, sqp_s3};

	always_ff @(posedge clk) begin
		// stage a result
		ent_s2      <= ent_s1;
		de_s2       <= de_mag;
		dp_s2       <= dp_mag;
		// stage b: squares
		ent_s3      <= ent_s2;
		sqe_s3      <= SQ_W'(de_s2) * SQ_W'(de_s2);
		sqp_s3      <= SQ_W'(dp_s2) * SQ_W'(dp_s2);
		// stage c: sum and cone test
		res_ent_s4  <= ent_s3;
		res_d2_s4   <= sum;
		res_hit_s4  <= ctl_s3.ok && (sum <= {1'b0, radius2});
	end

	assign busy = ctl_s2.vld || ctl_s3.vld || res_s4.vld;

endmodule

`default_nettype wire

@@ rtl/core/cone_nearest_match_remove_unit.sv @@
// top level of the cone nearest-match remove unit: sequencer, entry table, best tracker
// depends on cnmr_pkg, cnmr_ram and cnmr_dist
`default_nettype none

// Holds a table of up to MAX_ENTRIES objects (pt, eta, phi) and answers nearest
// match queries inside a delta-r cone. A clear item empties the table and a load
// item appends one entry (dropped when the table is full); neither of the two
// gives a result. A query item gives exactly one result: the nearest valid
// entry with pt >= pt_minimum and dEta^2 + dPhi^2 <= cone_radius_squared, phi
// wrapped at two_pi, lowest slot on a tie. The winning entry is removed from the
// table; with no match, found is 0 and all result fields are zero. A query walks
// the whole table through one shared distance unit, one entry per cycle, and
// holds the input stalled through the scan, the ram read, the draining of the
// three stage distance pipe and the move of the result into the output register.
// The result sits there; loads and clears go on while it waits, a following query
// waits at its end for the register to free up. The user must write configuration
// only while the unit is idle; the block itself does not enforce this.

module cone_nearest_match_remove_unit
	import cnmr_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// configuration
	input  wire logic                      cfg_write,
	input  wire logic [CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [CFG_DATA_W-1:0]     cfg_data,
	// input items
	input  wire logic                      in_valid,
	output      logic                      in_stall,
	input  wire logic [1:0]                kind,
	input  wire logic [PT_W-1:0]           obj_pt,
	input  wire logic signed [ANG_W-1:0]   obj_eta,
	input  wire logic signed [ANG_W-1:0]   obj_phi,
	// result items
	output      logic                      out_valid,
	input  wire logic                      out_stall,
	output      logic                      found,
	output      logic [OSLOT_W-1:0]        match_slot,
	output      logic [PT_W-1:0]           match_pt,
	output      logic signed [ANG_W-1:0]   match_eta,
	output      logic signed [ANG_W-1:0]   match_phi
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [PT_W-1:0] pt_min_q;
	logic [R2_W-1:0] radius2_q;
	logic [TP_W-1:0] two_pi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_min_q  <= PT_W'(2);
			radius2_q <= R2_W'(5898);
			two_pi_q  <= TP_W'(1608);
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_PT_MIN:  pt_min_q  <= cfg_data[PT_W-1:0];
				CFG_RADIUS2: radius2_q <= cfg_data[R2_W-1:0];
				CFG_TWO_PI:  two_pi_q  <= cfg_data[TP_W-1:0];
				default:     ;
			endcase
		end
	end

	// handshakes
	logic in_acc, out_free, done_fire;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;
	assign done_fire = (state_q == ST_DONE) && out_free;

	logic is_clear, is_load, is_query, can_load;
	assign is_clear = in_acc && (kind == KIND_CLEAR);
	assign is_load  = in_acc && (kind == KIND_LOAD);
	assign is_query = in_acc && (kind == KIND_QUERY);

	// table bookkeeping: fill count and per-slot valid flops
	logic [CNT_W-1:0]       entry_count_q;
	logic [MAX_ENTRIES-1:0] entry_valid_q;
	assign can_load = entry_count_q < CNT_W'(MAX_ENTRIES);

	// scan address and best-so-far
	logic [SLOT_W-1:0]       addr_q;
	logic signed [ANG_W-1:0] q_eta_q, q_phi_q;
	logic                    have_q;
	logic [SLOT_W-1:0]       best_slot_q;
	logic [D2_W-1:0]         best_d2_q;
	ent_t                    best_ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			entry_valid_q <= '0;
		end else begin
			if (is_clear) begin
				entry_count_q <= '0;
				entry_valid_q <= '0;
			end else if (is_load && can_load) begin
				entry_count_q                         <= entry_count_q + CNT_W'(1);
				entry_valid_q[entry_count_q[SLOT_W-1:0]] <= 1'b1;
			end else if (done_fire && have_q) begin
				// matched entry leaves the table, its slot stays used
				entry_valid_q[best_slot_q] <= 1'b0;
			end
		end
	end

	// entry storage
	ent_t ram_wdata, ent_s1;
	assign ram_wdata = '{pt: obj_pt, eta: obj_eta, phi: obj_phi};

	cnmr_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (is_load && can_load),
		.waddr (entry_count_q[SLOT_W-1:0]),
		.wdata (ram_wdata),
		.raddr (addr_q),
		.rdata (ent_s1)
	);

	// control stage aligned with the registered ram read
	cand_ctl_t cand_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_s1 <= '0;
		end else begin
			cand_s1.vld  <= (state_q == ST_SCAN);
			cand_s1.ok   <= entry_valid_q[addr_q];
			cand_s1.slot <= addr_q;
		end
	end

	// shared distance unit
	cand_ctl_t       res_s4;
	ent_t            res_ent_s4;
	logic [D2_W-1:0] res_d2_s4;
	logic            res_hit_s4, dist_busy;

	cnmr_dist u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.cand_s1    (cand_s1),
		.ent_s1     (ent_s1),
		.q_eta      (q_eta_q),
		.q_phi      (q_phi_q),
		.pt_min     (pt_min_q),
		.two_pi     (two_pi_q),
		.radius2    (radius2_q),
		.res_s4     (res_s4),
		.res_ent_s4 (res_ent_s4),
		.res_d2_s4  (res_d2_s4),
		.res_hit_s4 (res_hit_s4),
		.busy       (dist_busy)
	);

	// strict less-than keeps the lowest slot on a tie, slots arrive in order
	logic take;
	assign take = res_s4.vld && res_hit_s4 && (!have_q || (res_d2_s4 < best_d2_q));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
			have_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (is_query) begin
						state_q <= ST_SCAN;
						addr_q  <= '0;
						have_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (addr_q == SLOT_W'(MAX_ENTRIES - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + SLOT_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!cand_s1.vld && !dist_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (take) begin
				have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_query) begin
			q_eta_q <= obj_eta;
			q_phi_q <= obj_phi;
		end
		if (take) begin
			best_slot_q <= res_s4.slot;
			best_d2_q   <= res_d2_s4;
			best_ent_q  <= res_ent_s4;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (done_fire) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			found      <= have_q;
			match_slot <= have_q ? OSLOT_W'(best_slot_q) : '0;
			match_pt   <= have_q ? best_ent_q.pt : '0;
			match_eta  <= have_q ? best_ent_q.eta : '0;
			match_phi  <= have_q ? best_ent_q.phi : '0;
		end
	end

	// a result only appears at the end of a query scan
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result appeared outside the end of a scan");

	// the distance pipe is empty whenever the unit takes items
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!cand_s1.vld && !dist_busy))
		else $error("distance pipe busy while idle");

	// a matched entry is removed from the table
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_fire && have_q) |=> !entry_valid_q[$past(best_slot_q)])
		else $error("matched entry still valid");

	// fill count never passes the table depth
	assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count overflow");

endmodule

`default_nettype wire
